[rtl/mcps_pkg.sv]
`timescale 1ns / 1ps
// mountain car step unit: shared types, constants and cosine table
package mcps_pkg;

  localparam int COSINE_TABLE_BITS = 10;
  localparam int TABLE_SIZE        = 1 << COSINE_TABLE_BITS;
  localparam int QUARTER           = TABLE_SIZE / 4;
  localparam int FRAC_BITS         = 32 - COSINE_TABLE_BITS;

  localparam logic signed [31:0] START_POS   = -32'sd8388608;
  localparam logic signed [33:0] ONE_Q24_W   = 34'sd16777216;
  localparam logic signed [25:0] ONE_Q24     = 26'sd16777216;
  // 3 * turns per radian, Q32
  localparam logic [30:0]        PHASE_GAIN  = 31'd2050695828;
  // 0.001 in Q24, scaled by 64
  localparam logic [20:0]        PUSH_GAIN   = 21'd1073728;
  localparam logic [15:0]        GRAVITY_Q24 = 16'd41943;

  localparam int MODE_CONT = 0;
  localparam int MODE_NORM = 1;
  localparam int MODE_SWAP = 2;

  typedef enum logic [2:0] {
    REG_MIN_POS  = 3'd0,
    REG_MAX_POS  = 3'd1,
    REG_GOAL_POS = 3'd2,
    REG_MAX_VEL  = 3'd3,
    REG_MOD_VEL  = 3'd4,
    REG_TPS      = 3'd5,
    REG_MODE     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] min_pos;
    logic [31:0] max_pos;
    logic [31:0] goal_pos;
    logic [30:0] max_vel;
    logic [30:0] mod_vel;
    logic [15:0] trials_per_swap;
    logic [2:0]  mode;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PHASE,
    ST_ROM,
    ST_INTERP,
    ST_GRAV,
    ST_VEL,
    ST_POS,
    ST_DIV_INIT,
    ST_DIV,
    ST_SWAP,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic load_in;
    logic phase_en;
    logic rom_en;
    logic interp_en;
    logic grav_en;
    logic vel_en;
    logic pos_en;
    logic div_start;
    logic div_step;
    logic restart_en;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic op_step;
    logic goal_hit;
    logic div_last;
  } dp_stat_t;

  typedef logic signed [31:0] cos_table_t [TABLE_SIZE];

  // taylor series of cos over one quarter turn, Q30
  // term n is divided by (2n-1)*2n, n = 1..9
  function automatic longint quarter_cos(input longint r);
    longint x;
    longint x2;
    longint term;
    longint sum;
    x    = (r * 64'sd6746518852) >>> COSINE_TABLE_BITS;
    x2   = (x * x) / 64'sd1073741824;
    term = 64'sd1073741824;
    sum  = term;
    term = -((term * x2) / 64'sd1073741824) / 64'sd2;
    sum  = sum + term;
    term = -((term * x2) / 64'sd1073741824) / 64'sd12;
    sum  = sum + term;
    term = -((term * x2) / 64'sd1073741824) / 64'sd30;
    sum  = sum + term;
    term = -((term * x2) / 64'sd1073741824) / 64'sd56;
    sum  = sum + term;
    term = -((term * x2) / 64'sd1073741824) / 64'sd90;
    sum  = sum + term;
    term = -((term * x2) / 64'sd1073741824) / 64'sd132;
    sum  = sum + term;
    term = -((term * x2) / 64'sd1073741824) / 64'sd182;
    sum  = sum + term;
    term = -((term * x2) / 64'sd1073741824) / 64'sd240;
    sum  = sum + term;
    term = -((term * x2) / 64'sd1073741824) / 64'sd306;
    sum  = sum + term;
    if (sum > 64'sd1073741824) sum = 64'sd1073741824;
    if (sum < -64'sd1073741824) sum = -64'sd1073741824;
    return sum;
  endfunction

  function automatic cos_table_t build_cos_table();
    cos_table_t t;
    longint     c;
    int         quad;
    int         r;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      quad = k / QUARTER;
      r    = k % QUARTER;
      case (quad)
        0:       c = quarter_cos(longint'(r));
        1:       c = -quarter_cos(longint'(QUARTER - r));
        2:       c = -quarter_cos(longint'(r));
        default: c = quarter_cos(longint'(QUARTER - r));
      endcase
      t[k] = 32'(c);
    end
    return t;
  endfunction

  localparam cos_table_t COS_TABLE = build_cos_table();

endpackage

[rtl/mcps_cfg.sv]
`timescale 1ns / 1ps
// mountain car step unit: configuration register file
module mcps_cfg
  import mcps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_pos         <= -32'sd20132659;
      cfg_r.max_pos         <= 32'd10066330;
      cfg_r.goal_pos        <= 32'd10066330;
      cfg_r.max_vel         <= 31'd1174405;
      cfg_r.mod_vel         <= 31'd671089;
      cfg_r.trials_per_swap <= 16'd1;
      cfg_r.mode            <= 3'd1;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_POS:  cfg_r.min_pos         <= cfg_data;
        REG_MAX_POS:  cfg_r.max_pos         <= cfg_data;
        REG_GOAL_POS: cfg_r.goal_pos        <= cfg_data;
        REG_MAX_VEL:  cfg_r.max_vel         <= cfg_data[30:0];
        REG_MOD_VEL:  cfg_r.mod_vel         <= cfg_data[30:0];
        REG_TPS:      cfg_r.trials_per_swap <= cfg_data[15:0];
        REG_MODE:     cfg_r.mode            <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/mcps_ctrl.sv]
`timescale 1ns / 1ps
// mountain car step unit: sequencing state machine and output word valid
module mcps_ctrl
  import mcps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_operation,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  logic        out_valid_r;
  logic        in_accept;
  logic        out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = in_operation ? ST_PHASE : ST_DIV_INIT;
      end
      ST_PHASE:  state_nxt = ST_ROM;
      ST_ROM:    state_nxt = ST_INTERP;
      ST_INTERP: state_nxt = ST_GRAV;
      ST_GRAV:   state_nxt = ST_VEL;
      ST_VEL:    state_nxt = ST_POS;
      ST_POS:    state_nxt = ST_DIV_INIT;
      ST_DIV_INIT: begin
        // restart items and goal steps go through the remainder unit
        state_nxt = (!stat.op_step || stat.goal_hit) ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (stat.div_last) state_nxt = ST_SWAP;
      end
      ST_SWAP: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE:     cmd.load_in    = in_accept;
      ST_PHASE:    cmd.phase_en   = 1'b1;
      ST_ROM:      cmd.rom_en     = 1'b1;
      ST_INTERP:   cmd.interp_en  = 1'b1;
      ST_GRAV:     cmd.grav_en    = 1'b1;
      ST_VEL:      cmd.vel_en     = 1'b1;
      ST_POS:      cmd.pos_en     = 1'b1;
      ST_DIV_INIT: cmd.div_start  = 1'b1;
      ST_DIV:      cmd.div_step   = 1'b1;
      ST_SWAP:     cmd.restart_en = 1'b1;
      ST_DONE:     cmd.out_load   = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

[rtl/mcps_dp.sv]
`timescale 1ns / 1ps
// mountain car step unit: car state, cosine lookup, physics update, remainder unit
module mcps_dp
  import mcps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  cfg_t        cfg,
  input  logic        in_operation,
  input  logic [31:0] in_push_score_left,
  input  logic [31:0] in_push_score_none,
  input  logic [31:0] in_push_score_right,
  output logic [31:0] out_position_out,
  output logic [31:0] out_velocity_out,
  output logic        out_goal_reached,
  output logic        out_modified_limit_active
);

  // car and episode state
  logic signed [31:0] car_pos_r;
  logic signed [31:0] car_vel_r;
  logic [31:0]        trial_count_r;
  logic [15:0]        trials_since_swap_r;
  logic               mod_limit_r;

  // per-item working registers
  logic                         op_r;
  logic signed [25:0]           push_r;
  logic [31:0]                  phase_r;
  logic signed [31:0]           c0_r;
  logic signed [31:0]           c1_r;
  logic [FRAC_BITS-1:0]         frac_r;
  logic signed [47:0]           push_term_r;
  logic signed [31:0]           cos_r;
  logic signed [48:0]           grav_r;
  logic signed [31:0]           vel_tmp_r;
  logic                         goal_r;

  // remainder unit
  logic [31:0] tc_new_r;
  logic [31:0] div_sh_r;
  logic [15:0] rem_r;
  logic [2:0]  cnt_r;

  // output word
  logic [31:0] out_pos_r;
  logic [31:0] out_vel_r;
  logic        out_goal_r;
  logic        out_mod_r;

  logic signed [31:0] min_pos;
  logic signed [31:0] max_pos;
  logic signed [31:0] goal_pos;
  assign min_pos  = $signed(cfg.min_pos);
  assign max_pos  = $signed(cfg.max_pos);
  assign goal_pos = $signed(cfg.goal_pos);

  // push selection
  logic signed [31:0] s0;
  logic signed [31:0] s1;
  logic signed [31:0] s2;
  logic signed [33:0] cont_a;
  logic signed [25:0] push_nxt;

  assign s0 = $signed(in_push_score_left);
  assign s1 = $signed(in_push_score_none);
  assign s2 = $signed(in_push_score_right);

  always_comb begin
    cont_a = 34'(s0);
    if (cfg.mode[MODE_NORM]) cont_a = (34'(s0) <<< 1) - ONE_Q24_W;
    if (cfg.mode[MODE_CONT]) begin
      if (cont_a > ONE_Q24_W) begin
        push_nxt = ONE_Q24;
      end else if (cont_a < -ONE_Q24_W) begin
        push_nxt = -ONE_Q24;
      end else begin
        push_nxt = cont_a[25:0];
      end
    end else begin
      // ties without a strict winner push left
      push_nxt = -ONE_Q24;
      if (s1 > s0 && s1 > s2) push_nxt = '0;
      if (s2 > s0 && s2 > s1) push_nxt = ONE_Q24;
    end
  end

  // phase of 3*position in 2^-32 turns
  logic signed [63:0] phase_prod;
  assign phase_prod = car_pos_r * $signed({1'b0, PHASE_GAIN});

  logic [COSINE_TABLE_BITS-1:0] tab_idx;
  logic [COSINE_TABLE_BITS-1:0] tab_idx_inc;
  assign tab_idx     = phase_r[31:FRAC_BITS];
  assign tab_idx_inc = tab_idx + {{(COSINE_TABLE_BITS-1){1'b0}}, 1'b1};

  // interpolation between neighboring entries, floored
  logic signed [32:0]           cos_diff;
  logic signed [33+FRAC_BITS:0] interp_prod;
  logic signed [33+FRAC_BITS:0] interp_shift;
  logic signed [31:0]           cos_nxt;
  assign cos_diff     = 33'(c1_r) - 33'(c0_r);
  assign interp_prod  = cos_diff * $signed({1'b0, frac_r});
  assign interp_shift = interp_prod >>> FRAC_BITS;
  assign cos_nxt      = c0_r + interp_shift[31:0];

  // velocity update and clamp
  logic signed [49:0] dv_num;
  logic signed [49:0] dv_shift;
  logic signed [33:0] vel_sum;
  logic signed [33:0] vel_lim;
  logic signed [31:0] vel_nxt;
  assign dv_num   = 50'(push_term_r) - 50'(grav_r);
  assign dv_shift = dv_num >>> 30;
  assign vel_sum  = 34'(car_vel_r) + 34'($signed(dv_shift[19:0]));
  assign vel_lim  = $signed({3'b000, (mod_limit_r ? cfg.mod_vel : cfg.max_vel)});

  always_comb begin
    if (vel_sum > vel_lim) begin
      vel_nxt = vel_lim[31:0];
    end else if (vel_sum < -vel_lim) begin
      vel_nxt = -vel_lim[31:0];
    end else begin
      vel_nxt = vel_sum[31:0];
    end
  end

  // position update, clamps, left wall
  logic signed [32:0] pos_sum;
  logic signed [31:0] pos_nxt;
  logic signed [31:0] vel_wall;
  assign pos_sum = 33'(car_pos_r) + 33'(vel_tmp_r);

  always_comb begin
    pos_nxt = pos_sum[31:0];
    if (pos_sum > 33'(max_pos)) pos_nxt = max_pos;
    if ($signed(33'(pos_nxt)) < 33'(min_pos) || pos_sum < 33'(min_pos)) begin
      if (pos_sum < 33'(min_pos) || pos_nxt < min_pos) pos_nxt = min_pos;
    end
    vel_wall = vel_tmp_r;
    if (pos_nxt == min_pos && vel_tmp_r < 0) vel_wall = '0;
  end

  // four dividend bits a cycle
  logic [15:0] divisor;
  logic [16:0] rem_w;
  logic [15:0] rem_nxt;
  assign divisor = (cfg.trials_per_swap == '0) ? 16'd1 : cfg.trials_per_swap;

  always_comb begin
    rem_w = {1'b0, rem_r};
    for (int j = 0; j < 4; j++) begin
      rem_w = {rem_w[15:0], div_sh_r[31-j]};
      if (rem_w >= {1'b0, divisor}) rem_w = rem_w - {1'b0, divisor};
    end
    rem_nxt = rem_w[15:0];
  end

  logic swap_now;
  assign swap_now = cfg.mode[MODE_SWAP] && (rem_r == '0);

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= in_operation;
      push_r <= push_nxt;
    end
    if (cmd.phase_en) phase_r <= phase_prod[55:24];
    if (cmd.rom_en) begin
      c0_r        <= COS_TABLE[tab_idx];
      c1_r        <= COS_TABLE[tab_idx_inc];
      frac_r      <= phase_r[FRAC_BITS-1:0];
      push_term_r <= push_r * $signed({1'b0, PUSH_GAIN});
    end
    if (cmd.interp_en) cos_r <= cos_nxt;
    if (cmd.grav_en) grav_r <= cos_r * $signed({1'b0, GRAVITY_Q24});
    if (cmd.vel_en) vel_tmp_r <= vel_nxt;
    if (cmd.div_start) begin
      tc_new_r <= trial_count_r + 32'd1;
      div_sh_r <= trial_count_r + 32'd1;
      rem_r    <= '0;
      cnt_r    <= '0;
    end else if (cmd.div_step) begin
      div_sh_r <= {div_sh_r[27:0], 4'b0000};
      rem_r    <= rem_nxt;
      cnt_r    <= cnt_r + 3'd1;
    end
    if (cmd.out_load) begin
      out_pos_r  <= car_pos_r;
      out_vel_r  <= car_vel_r;
      out_goal_r <= goal_r;
      out_mod_r  <= mod_limit_r;
    end
  end

  // car and episode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      car_pos_r           <= START_POS;
      car_vel_r           <= '0;
      trial_count_r       <= '1;
      trials_since_swap_r <= '0;
      mod_limit_r         <= 1'b0;
      goal_r              <= 1'b0;
    end else begin
      if (cmd.load_in) goal_r <= 1'b0;
      if (cmd.pos_en) begin
        car_pos_r <= pos_nxt;
        car_vel_r <= vel_wall;
        goal_r    <= (pos_nxt >= goal_pos);
      end
      if (cmd.restart_en) begin
        trial_count_r <= tc_new_r;
        car_pos_r     <= START_POS;
        car_vel_r     <= '0;
        if (swap_now) begin
          mod_limit_r         <= !mod_limit_r;
          trials_since_swap_r <= '0;
        end else begin
          trials_since_swap_r <= trials_since_swap_r + 16'd1;
        end
      end
    end
  end

  assign stat.op_step  = op_r;
  assign stat.goal_hit = goal_r;
  assign stat.div_last = (cnt_r == 3'd7);

  assign out_position_out          = out_pos_r;
  assign out_velocity_out          = out_vel_r;
  assign out_goal_reached          = out_goal_r;
  assign out_modified_limit_active = out_mod_r;

endmodule

[rtl/mountain_car_physics_step_unit.sv]
`timescale 1ns / 1ps
// a step word runs the phase, ROM, interpolation, gravity, velocity and position states, then
// the remainder unit and restart only when it reaches the goal; a restart word goes straight there
// one word at a time, held off while the output stalls; the cosine lookup, interpolation and two
// multiply stages set the step path, the remainder unit (4 bits a cycle) the restart path
// reset: synchronous active low; config, control and car state registers to defaults, car at -0.5, no clearing pass
module mountain_car_physics_step_unit
  import mcps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [31:0] in_push_score_left,
  input  logic [31:0] in_push_score_none,
  input  logic [31:0] in_push_score_right,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_position_out,
  output logic [31:0] out_velocity_out,
  output logic        out_goal_reached,
  output logic        out_modified_limit_active,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  mcps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mcps_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  mcps_dp u_dp (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cmd                       (cmd),
    .stat                      (stat),
    .cfg                       (cfg),
    .in_operation              (in_operation),
    .in_push_score_left        (in_push_score_left),
    .in_push_score_none        (in_push_score_none),
    .in_push_score_right       (in_push_score_right),
    .out_position_out          (out_position_out),
    .out_velocity_out          (out_velocity_out),
    .out_goal_reached          (out_goal_reached),
    .out_modified_limit_active (out_modified_limit_active)
  );

endmodule

[rtl/mcps_checker.sv]
`timescale 1ns / 1ps
// mountain car step unit: port checker and its bind
module mcps_checker
  import mcps_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_position_out,
  input logic [31:0] out_velocity_out,
  input logic        out_goal_reached,
  input logic        out_modified_limit_active
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_position_out) && $stable(out_velocity_out)
      && $stable(out_goal_reached) && $stable(out_modified_limit_active))
    else $error("result word changed while stalled");

  // one word in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");

  // reaching the goal restarts the car
  a_goal_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_goal_reached |-> $signed(out_position_out) == START_POS
      && out_velocity_out == 32'd0)
    else $error("goal word without restarted car");

endmodule

bind mountain_car_physics_step_unit mcps_checker u_mcps_checker (
  .clk                       (clk),
  .rst_n                     (rst_n),
  .in_valid                  (in_valid),
  .in_ready                  (in_ready),
  .out_valid                 (out_valid),
  .out_ready                 (out_ready),
  .out_position_out          (out_position_out),
  .out_velocity_out          (out_velocity_out),
  .out_goal_reached          (out_goal_reached),
  .out_modified_limit_active (out_modified_limit_active)
);
